FILE: hw/rtl/twodo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twodo_pkg
// Shared widths, fixed-point constants, sequencer operation codes and the
// command/status structs between the odometry controller and datapath.
// ----------------------------------------------------------------------------
package twodo_pkg;

    // Field widths
    localparam int CNT_W = 32;          // encoder count
    localparam int CFG_W = 24;          // configuration register
    localparam int CFG_IDX_W = 2;
    localparam int POS_W = 32;          // position, Q16.16
    localparam int HDG_W = 19;          // heading, unsigned Q3.16
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 88;

    // Internal arithmetic widths
    localparam int XW = 64;             // wide operand / result of the serial unit
    localparam int YW = 26;             // narrow operand of the serial unit
    localparam int AW = 20;             // signed angle, Q3.16
    localparam int SCW = 20;            // signed sine / cosine, Q3.16
    localparam int CW = 34;             // CORDIC vector, Q30
    localparam int CSTEPS = 16;
    localparam int CS_W = 4;

    localparam logic signed [AW:0] TWO_PI_Q = 21'sd411775;
    localparam logic signed [AW:0] PI_Q = 21'sd205887;
    localparam logic signed [AW:0] HALF_PI_Q = 21'sd102944;
    localparam logic signed [CW-1:0] CORDIC_K_Q30 = 34'sd652032874;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IPT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_OFS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_OFS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_OFS = 2'd3;

    // Sequencer operations
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_SCALE_L = 5'd0;
    localparam logic [OP_W-1:0] OP_SCALE_R = 5'd1;
    localparam logic [OP_W-1:0] OP_SCALE_B = 5'd2;
    localparam logic [OP_W-1:0] OP_ANGLE = 5'd3;
    localparam logic [OP_W-1:0] OP_ANG_ZERO = 5'd4;
    localparam logic [OP_W-1:0] OP_SIN_A = 5'd5;
    localparam logic [OP_W-1:0] OP_DR_SA = 5'd6;
    localparam logic [OP_W-1:0] OP_DIV_DR = 5'd7;
    localparam logic [OP_W-1:0] OP_RO_SA = 5'd8;
    localparam logic [OP_W-1:0] OP_DB_SA = 5'd9;
    localparam logic [OP_W-1:0] OP_DIV_DB = 5'd10;
    localparam logic [OP_W-1:0] OP_BO_SA = 5'd11;
    localparam logic [OP_W-1:0] OP_STRAIGHT = 5'd12;
    localparam logic [OP_W-1:0] OP_HEAD = 5'd13;
    localparam logic [OP_W-1:0] OP_SIN_H = 5'd14;
    localparam logic [OP_W-1:0] OP_X1 = 5'd15;
    localparam logic [OP_W-1:0] OP_X2 = 5'd16;
    localparam logic [OP_W-1:0] OP_Y1 = 5'd17;
    localparam logic [OP_W-1:0] OP_Y2 = 5'd18;

    typedef struct packed {
        logic            load;
        logic            start;
        logic            wb;
        logic            publish;
        logic [OP_W-1:0] op;
    } twodo_cmd_t;

    typedef struct packed {
        logic done;
        logic denom_zero;
        logic ang_zero;
    } twodo_sts_t;

    function automatic logic signed [AW:0] atan_q16(input logic [CS_W-1:0] i);
        logic signed [AW:0] r;
        case (i)
            4'd0:    r = 21'sd51472;
            4'd1:    r = 21'sd30386;
            4'd2:    r = 21'sd16055;
            4'd3:    r = 21'sd8150;
            4'd4:    r = 21'sd4091;
            4'd5:    r = 21'sd2047;
            4'd6:    r = 21'sd1024;
            4'd7:    r = 21'sd512;
            4'd8:    r = 21'sd256;
            4'd9:    r = 21'sd128;
            4'd10:   r = 21'sd64;
            4'd11:   r = 21'sd32;
            4'd12:   r = 21'sd16;
            4'd13:   r = 21'sd8;
            4'd14:   r = 21'sd4;
            default: r = 21'sd2;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/three_wheel_odometry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_wheel_odometry
// Three tracking wheel arc odometry in Q16.16 fixed point.
//
//   Channel  Dir  Word                                   Handshake
//   s_       in   left, right, back encoder counts       tvalid/tready
//   m_       out  pos_x, pos_y, heading                  tvalid/tready
//   cfg_     in   register index + 24-bit data           write enable only
//
// One word at a time. The operation sequence differs when the offset sum is
// zero, when the heading change is otherwise zero and on an arc; it runs on
// the bit-serial multiply/divide unit and the 16-step CORDIC.
// Reset clears the configuration, the count history and the pose.
// The result sits in an output register, so a stalled m_ side holds only
// the publish step of the next word.
// ----------------------------------------------------------------------------
module three_wheel_odometry (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // left_count[31:0], right_count[63:32], back_count[95:64]
    input  logic [twodo_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pos_x[31:0], pos_y[63:32], heading[82:64], zero pad[87:83]
    output logic [twodo_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [twodo_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [twodo_pkg::CFG_W-1:0]         cfg_wdata
);
    import twodo_pkg::*;

    twodo_cmd_t       cmd;
    twodo_sts_t       sts;
    logic [POS_W-1:0] pos_x, pos_y;
    logic [HDG_W-1:0] heading;

    twodo_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    twodo_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .left_count  (s_tdata[CNT_W-1:0]),
        .right_count (s_tdata[2*CNT_W-1:CNT_W]),
        .back_count  (s_tdata[3*CNT_W-1:2*CNT_W]),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .heading     (heading)
    );

    assign m_tdata = {{(M_TDATA_W - 2*POS_W - HDG_W){1'b0}}, heading, pos_y, pos_x};

endmodule

FILE: hw/rtl/twodo_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twodo_muldiv
// Bit-serial signed multiplier (one bit of y per cycle) and restoring
// divider (one quotient bit per cycle, truncating toward zero).
// ----------------------------------------------------------------------------
module twodo_muldiv (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start_mul,
    input  logic                            start_div,
    input  logic signed [twodo_pkg::XW-1:0] x,
    input  logic signed [twodo_pkg::YW-1:0] y,
    output logic signed [twodo_pkg::XW-1:0] res,
    output logic                            done
);
    import twodo_pkg::*;

    localparam logic [1:0] MD_IDLE = 2'd0;
    localparam logic [1:0] MD_MUL = 2'd1;
    localparam logic [1:0] MD_DIV = 2'd2;
    localparam int CNT_BITS = $clog2(XW);

    logic [1:0]           state_reg, state_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic signed [XW-1:0] acc_reg, acc_next;
    logic [XW-1:0]        xs_reg, xs_next;
    logic [YW-1:0]        ys_reg, ys_next;
    logic [YW-1:0]        rem_reg, rem_next;
    logic                 neg_reg, neg_next;
    logic signed [XW-1:0] res_reg, res_next;
    logic                 done_reg, done_next;

    logic [XW-1:0]        addend;
    logic [YW:0]          rem_sh;
    logic                 qbit;

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        xs_next = xs_reg;
        ys_next = ys_reg;
        rem_next = rem_reg;
        neg_next = neg_reg;
        res_next = res_reg;
        done_next = 1'b0;
        addend = ys_reg[0] ? xs_reg : '0;
        rem_sh = {rem_reg, xs_reg[XW-1]};
        qbit = (rem_sh >= {1'b0, ys_reg});
        case (state_reg)
            MD_IDLE: begin
                cnt_next = '0;
                if (start_mul) begin
                    acc_next = '0;
                    xs_next = x;
                    ys_next = y;
                    state_next = MD_MUL;
                end else if (start_div) begin
                    xs_next = x[XW-1] ? XW'(-x) : XW'(x);
                    ys_next = y[YW-1] ? YW'(-y) : YW'(y);
                    rem_next = '0;
                    neg_next = x[XW-1] ^ y[YW-1];
                    state_next = MD_DIV;
                end
            end
            MD_MUL: begin
                // top bit of y carries negative weight
                if (cnt_reg == CNT_BITS'(YW - 1)) begin
                    acc_next = acc_reg - $signed(addend);
                    res_next = acc_reg - $signed(addend);
                    done_next = 1'b1;
                    state_next = MD_IDLE;
                end else begin
                    acc_next = acc_reg + $signed(addend);
                end
                xs_next = {xs_reg[XW-2:0], 1'b0};
                ys_next = {1'b0, ys_reg[YW-1:1]};
                cnt_next = cnt_reg + 1'b1;
            end
            MD_DIV: begin
                rem_next = qbit ? YW'(rem_sh - {1'b0, ys_reg}) : rem_sh[YW-1:0];
                xs_next = {xs_reg[XW-2:0], qbit};
                if (cnt_reg == CNT_BITS'(XW - 1)) begin
                    res_next = neg_reg ? -$signed({xs_reg[XW-2:0], qbit})
                                       : $signed({xs_reg[XW-2:0], qbit});
                    done_next = 1'b1;
                    state_next = MD_IDLE;
                end
                cnt_next = cnt_reg + 1'b1;
            end
            default: state_next = MD_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MD_IDLE;
            done_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        xs_reg <= xs_next;
        ys_reg <= ys_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign res = res_reg;
    assign done = done_reg;

endmodule

FILE: hw/rtl/twodo_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twodo_cordic
// Iterative rotation-mode CORDIC: folds the angle into [-pi/2, pi/2], runs
// sixteen micro-rotations on a Q30 vector and returns Q3.16 sine/cosine.
// ----------------------------------------------------------------------------
module twodo_cordic (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic signed [twodo_pkg::AW-1:0]  angle,
    output logic signed [twodo_pkg::SCW-1:0] sin_q,
    output logic signed [twodo_pkg::SCW-1:0] cos_q,
    output logic                             done
);
    import twodo_pkg::*;

    logic                  busy_reg, busy_next;
    logic [CS_W-1:0]       cnt_reg, cnt_next;
    logic signed [CW-1:0]  x_reg, x_next, y_reg, y_next;
    logic signed [AW:0]    z_reg, z_next;
    logic                  negc_reg, negc_next;
    logic signed [SCW-1:0] sin_reg, sin_next, cos_reg, cos_next;
    logic                  done_reg, done_next;

    logic signed [AW:0]    a0, a1, a2;
    logic signed [CW-1:0]  xsh, ysh, xr, yr, x14, y14;

    always_comb begin
        a0 = $signed({angle[AW-1], angle});
        a1 = (a0 > PI_Q) ? a0 - TWO_PI_Q : a0;
        a2 = (a1 < -PI_Q) ? a1 + TWO_PI_Q : a1;

        xsh = x_reg >>> cnt_reg;
        ysh = y_reg >>> cnt_reg;
        if (!z_reg[AW]) begin
            xr = x_reg - ysh;
            yr = y_reg + xsh;
        end else begin
            xr = x_reg + ysh;
            yr = y_reg - xsh;
        end
        x14 = xr >>> 14;
        y14 = yr >>> 14;

        busy_next = busy_reg;
        cnt_next = cnt_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        negc_next = negc_reg;
        sin_next = sin_reg;
        cos_next = cos_reg;
        done_next = 1'b0;

        if (!busy_reg) begin
            if (start) begin
                busy_next = 1'b1;
                cnt_next = '0;
                x_next = CORDIC_K_Q30;
                y_next = '0;
                if (a2 > HALF_PI_Q) begin
                    z_next = PI_Q - a2;
                    negc_next = 1'b1;
                end else if (a2 < -HALF_PI_Q) begin
                    z_next = -PI_Q - a2;
                    negc_next = 1'b1;
                end else begin
                    z_next = a2;
                    negc_next = 1'b0;
                end
            end
        end else begin
            x_next = xr;
            y_next = yr;
            z_next = z_reg[AW] ? z_reg + atan_q16(cnt_reg) : z_reg - atan_q16(cnt_reg);
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CS_W'(CSTEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                sin_next = y14[SCW-1:0];
                cos_next = negc_reg ? SCW'(-x14) : x14[SCW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        negc_reg <= negc_next;
        sin_reg <= sin_next;
        cos_reg <= cos_next;
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;
    assign done = done_reg;

endmodule

FILE: hw/rtl/twodo_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twodo_dp
// Odometry datapath: configuration, count history, pose accumulators,
// working registers and the shared serial arithmetic and CORDIC units.
// ----------------------------------------------------------------------------
module twodo_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  twodo_pkg::twodo_cmd_t                cmd,
    output twodo_pkg::twodo_sts_t                sts,
    input  logic                                 cfg_wr_en,
    input  logic [twodo_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [twodo_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic [twodo_pkg::CNT_W-1:0]          left_count,
    input  logic [twodo_pkg::CNT_W-1:0]          right_count,
    input  logic [twodo_pkg::CNT_W-1:0]          back_count,
    output logic [twodo_pkg::POS_W-1:0]          pos_x,
    output logic [twodo_pkg::POS_W-1:0]          pos_y,
    output logic [twodo_pkg::HDG_W-1:0]          heading
);
    import twodo_pkg::*;

    localparam logic signed [XW-1:0] MAX32 = 64'sd2147483647;
    localparam logic signed [XW-1:0] MIN32 = -64'sd2147483648;
    localparam logic signed [XW-1:0] RND16 = 64'sd65535;
    localparam logic signed [XW-1:0] TWO_PI_X = XW'(TWO_PI_Q);

    function automatic logic [POS_W-1:0] sat32(input logic signed [XW-1:0] v);
        logic [POS_W-1:0] r;
        if (v > MAX32) r = MAX32[POS_W-1:0];
        else if (v < MIN32) r = MIN32[POS_W-1:0];
        else r = v[POS_W-1:0];
        return r;
    endfunction

    // divide by 2^16, rounding toward zero
    function automatic logic signed [XW-1:0] trunc16(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] r;
        if (v[XW-1]) r = (v + RND16) >>> 16;
        else r = v >>> 16;
        return r;
    endfunction

    // architectural state
    logic [CFG_W-1:0]       ipt_reg, lo_reg, ro_reg, bo_reg;
    logic [CNT_W-1:0]       prev_l_reg, prev_r_reg, prev_b_reg;
    logic signed [POS_W-1:0] acc_x_reg, acc_y_reg;
    logic [HDG_W-1:0]       acc_h_reg;

    // working registers
    logic [CNT_W-1:0]       raw_l_reg, raw_r_reg, raw_b_reg;
    logic signed [POS_W-1:0] dl_reg, dr_reg, db_reg;
    logic signed [AW-1:0]   ang_reg;
    logic signed [SCW-1:0]  sa_reg, sh_reg, ch_reg;
    logic signed [XW-1:0]   prod_reg, quo_reg, dist_reg, dist2_reg;
    logic [POS_W-1:0]       out_x_reg, out_y_reg;
    logic [HDG_W-1:0]       out_h_reg;

    // unit interface
    logic                   md_start_mul, md_start_div, md_done;
    logic signed [XW-1:0]   md_x, md_res;
    logic signed [YW-1:0]   md_y;
    logic                   cor_start, cor_done;
    logic signed [AW-1:0]   cor_angle;
    logic signed [SCW-1:0]  cor_sin, cor_cos;

    logic signed [AW:0]     h0, h1, h2;
    logic signed [XW-1:0]   ang_x;

    always_comb begin
        md_x = '0;
        md_y = '0;
        md_start_mul = 1'b0;
        md_start_div = 1'b0;
        case (cmd.op)
            OP_SCALE_L: begin
                md_x = XW'($signed(raw_l_reg));
                md_y = $signed(YW'(ipt_reg));
                md_start_mul = cmd.start;
            end
            OP_SCALE_R: begin
                md_x = XW'($signed(raw_r_reg));
                md_y = $signed(YW'(ipt_reg));
                md_start_mul = cmd.start;
            end
            OP_SCALE_B: begin
                md_x = XW'($signed(raw_b_reg));
                md_y = $signed(YW'(ipt_reg));
                md_start_mul = cmd.start;
            end
            OP_ANGLE: begin
                md_x = (XW'(dl_reg) - XW'(dr_reg)) <<< 16;
                md_y = $signed(YW'(lo_reg) + YW'(ro_reg));
                md_start_div = cmd.start;
            end
            OP_DR_SA: begin
                md_x = XW'(dr_reg);
                md_y = YW'(sa_reg);
                md_start_mul = cmd.start;
            end
            OP_DIV_DR, OP_DIV_DB: begin
                md_x = prod_reg;
                md_y = YW'(ang_reg);
                md_start_div = cmd.start;
            end
            OP_RO_SA: begin
                md_x = $signed(XW'(ro_reg));
                md_y = YW'(sa_reg);
                md_start_mul = cmd.start;
            end
            OP_DB_SA: begin
                md_x = XW'(db_reg);
                md_y = YW'(sa_reg);
                md_start_mul = cmd.start;
            end
            OP_BO_SA: begin
                md_x = $signed(XW'(bo_reg));
                md_y = YW'(sa_reg);
                md_start_mul = cmd.start;
            end
            OP_X1: begin
                md_x = dist_reg;
                md_y = YW'(sh_reg);
                md_start_mul = cmd.start;
            end
            OP_X2: begin
                md_x = dist2_reg;
                md_y = YW'(ch_reg);
                md_start_mul = cmd.start;
            end
            OP_Y1: begin
                md_x = dist_reg;
                md_y = YW'(ch_reg);
                md_start_mul = cmd.start;
            end
            OP_Y2: begin
                md_x = dist2_reg;
                md_y = YW'(sh_reg);
                md_start_mul = cmd.start;
            end
            default: begin
                md_x = '0;
                md_y = '0;
            end
        endcase
    end

    assign cor_start = cmd.start && (cmd.op == OP_SIN_A || cmd.op == OP_SIN_H);
    assign cor_angle = (cmd.op == OP_SIN_A) ? ang_reg : $signed({1'b0, acc_h_reg});

    twodo_muldiv u_muldiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start_mul (md_start_mul),
        .start_div (md_start_div),
        .x         (md_x),
        .y         (md_y),
        .res       (md_res),
        .done      (md_done)
    );

    twodo_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .angle   (cor_angle),
        .sin_q   (cor_sin),
        .cos_q   (cor_cos),
        .done    (cor_done)
    );

    // heading wrap: subtract then add 2*pi at most once each
    always_comb begin
        h0 = $signed({2'b00, acc_h_reg}) + $signed({ang_reg[AW-1], ang_reg});
        h1 = (h0 > TWO_PI_Q) ? h0 - TWO_PI_Q : h0;
        h2 = h1[AW] ? h1 + TWO_PI_Q : h1;
        ang_x = md_res;
        if (md_res > TWO_PI_X) ang_x = TWO_PI_X;
        else if (md_res < -TWO_PI_X) ang_x = -TWO_PI_X;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ipt_reg <= '0;
            lo_reg <= '0;
            ro_reg <= '0;
            bo_reg <= '0;
            prev_l_reg <= '0;
            prev_r_reg <= '0;
            prev_b_reg <= '0;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            acc_h_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_IPT:       ipt_reg <= cfg_wdata;
                    CFG_LEFT_OFS:  lo_reg <= cfg_wdata;
                    CFG_RIGHT_OFS: ro_reg <= cfg_wdata;
                    CFG_BACK_OFS:  bo_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.load) begin
                prev_l_reg <= left_count;
                prev_r_reg <= right_count;
                prev_b_reg <= back_count;
            end
            if (cmd.wb && cmd.op == OP_HEAD) begin
                acc_h_reg <= h2[HDG_W-1:0];
            end
            if (cmd.wb && cmd.op == OP_X2) begin
                acc_x_reg <= sat32(XW'(acc_x_reg) + trunc16(prod_reg + md_res));
            end
            if (cmd.wb && cmd.op == OP_Y2) begin
                acc_y_reg <= sat32(XW'(acc_y_reg) + trunc16(prod_reg - md_res));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            raw_l_reg <= left_count - prev_l_reg;
            raw_r_reg <= right_count - prev_r_reg;
            raw_b_reg <= back_count - prev_b_reg;
        end
        if (cmd.publish) begin
            out_x_reg <= acc_x_reg;
            out_y_reg <= acc_y_reg;
            out_h_reg <= acc_h_reg;
        end
        if (cmd.wb) begin
            case (cmd.op)
                OP_SCALE_L:  dl_reg <= sat32(md_res);
                OP_SCALE_R:  dr_reg <= sat32(md_res);
                OP_SCALE_B:  db_reg <= sat32(md_res);
                OP_ANGLE:    ang_reg <= ang_x[AW-1:0];
                OP_ANG_ZERO: ang_reg <= '0;
                OP_SIN_A:    sa_reg <= cor_sin;
                OP_DR_SA:    prod_reg <= md_res;
                OP_DIV_DR:   quo_reg <= md_res;
                OP_RO_SA:    dist_reg <= quo_reg + trunc16(md_res);
                OP_DB_SA:    prod_reg <= md_res;
                OP_DIV_DB:   quo_reg <= md_res;
                OP_BO_SA:    dist2_reg <= quo_reg + trunc16(md_res);
                OP_STRAIGHT: begin
                    dist_reg <= XW'(dr_reg);
                    dist2_reg <= XW'(db_reg);
                end
                OP_SIN_H: begin
                    sh_reg <= cor_sin;
                    ch_reg <= cor_cos;
                end
                OP_X1:       prod_reg <= md_res;
                OP_Y1:       prod_reg <= md_res;
                default: ;
            endcase
        end
    end

    assign sts.done = md_done | cor_done;
    assign sts.denom_zero = (lo_reg == '0) && (ro_reg == '0);
    assign sts.ang_zero = (ang_reg == '0);

    assign pos_x = out_x_reg;
    assign pos_y = out_y_reg;
    assign heading = out_h_reg;

endmodule

FILE: hw/rtl/twodo_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twodo_ctrl
// Sequencer: walks the datapath through one odometry update per input word
// and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module twodo_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output twodo_pkg::twodo_cmd_t cmd,
    input  twodo_pkg::twodo_sts_t sts
);
    import twodo_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_PUB = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [OP_W-1:0] op_reg, op_next;
    logic            m_tvalid_reg, m_tvalid_next;

    function automatic logic [OP_W-1:0] seq_next(input logic [OP_W-1:0] op);
        logic [OP_W-1:0] r;
        case (op)
            OP_SCALE_L:  r = OP_SCALE_R;
            OP_SCALE_R:  r = OP_SCALE_B;
            OP_SCALE_B:  r = OP_ANGLE;
            OP_ANGLE:    r = OP_SIN_A;
            OP_ANG_ZERO: r = OP_SIN_A;
            OP_SIN_A:    r = OP_DR_SA;
            OP_DR_SA:    r = OP_DIV_DR;
            OP_DIV_DR:   r = OP_RO_SA;
            OP_RO_SA:    r = OP_DB_SA;
            OP_DB_SA:    r = OP_DIV_DB;
            OP_DIV_DB:   r = OP_BO_SA;
            OP_BO_SA:    r = OP_HEAD;
            OP_STRAIGHT: r = OP_HEAD;
            OP_HEAD:     r = OP_SIN_H;
            OP_SIN_H:    r = OP_X1;
            OP_X1:       r = OP_X2;
            OP_X2:       r = OP_Y1;
            OP_Y1:       r = OP_Y2;
            default:     r = OP_SCALE_L;
        endcase
        return r;
    endfunction

    always_comb begin
        state_next = state_reg;
        op_next = op_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        cmd = '0;
        cmd.op = op_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    op_next = OP_SCALE_L;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (op_reg == OP_ANGLE && sts.denom_zero) begin
                    op_next = OP_ANG_ZERO;
                end else if (op_reg == OP_SIN_A && sts.ang_zero) begin
                    op_next = OP_STRAIGHT;
                end else if (op_reg inside {OP_ANG_ZERO, OP_STRAIGHT, OP_HEAD}) begin
                    // ops that use no unit write back at once
                    cmd.wb = 1'b1;
                    op_next = seq_next(op_reg);
                end else begin
                    cmd.start = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (sts.done) begin
                    cmd.wb = 1'b1;
                    if (op_reg == OP_Y2) begin
                        state_next = ST_PUB;
                    end else begin
                        op_next = seq_next(op_reg);
                        state_next = ST_RUN;
                    end
                end
            end
            ST_PUB: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    cmd.publish = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg <= OP_SCALE_L;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg <= op_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

`ifndef ASSERT_OFF
    a_done_only_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.done |-> state_reg == ST_WAIT)
        else $error("unit finished while sequencer not waiting");

    a_no_instant_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> !sts.done)
        else $error("unit finished one cycle after start");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |-> !(m_tvalid_reg && !m_tready))
        else $error("pending result overwritten");

    a_wait_real_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WAIT |-> (op_reg != OP_ANG_ZERO && op_reg != OP_STRAIGHT
                                  && op_reg != OP_HEAD))
        else $error("waiting on a single-cycle op");
`endif

endmodule
